>>> rtl/core/byte_stack_machine_execute_defines.svh
// Assertion macros for the byte stack machine execute unit.
// Each macro expects clk and rst_n in scope where it is used.
`ifndef BYTE_STACK_MACHINE_EXECUTE_DEFINES_SVH
`define BYTE_STACK_MACHINE_EXECUTE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BSM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsm same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define BSM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsm next-cycle check failed");

`endif

>>> rtl/core/bsm_pkg.sv
// Shared types and constants of the byte stack machine execute unit.
// No dependencies; bsm_in_if, bsm_alu and the execute unit import it.
`default_nettype none

package bsm_pkg;

    localparam int unsigned OP_BITS   = 5;
    localparam int unsigned SLOT_BITS = 32;

    typedef enum logic [4:0] {
        OP_HALT  = 5'd0,
        OP_PUSH  = 5'd1,
        OP_POP   = 5'd2,
        OP_ADD   = 5'd3,
        OP_SUB   = 5'd4,
        OP_MUL   = 5'd5,
        OP_DIV   = 5'd6,
        OP_MOV   = 5'd7,
        OP_JMP   = 5'd8,
        OP_SWAP  = 5'd9,
        OP_PUSHX = 5'd10,
        OP_POPX  = 5'd11,
        OP_JE    = 5'd12,
        OP_JNE   = 5'd13,
        OP_JLT   = 5'd14,
        OP_JGT   = 5'd15,
        OP_SETX  = 5'd16,
        OP_GETX  = 5'd17
    } bsm_op_t;

    typedef enum logic [2:0] {
        F_NONE  = 3'd0,
        F_UNDER = 3'd1,
        F_OVER  = 3'd2,
        F_DIVZ  = 3'd3,
        F_SLOT  = 3'd4
    } bsm_fault_t;

    // Instruction lengths in code bytes
    localparam int unsigned LEN_SHORT = 1;
    localparam int unsigned LEN_PUSH  = 2;
    localparam int unsigned LEN_JUMP  = 2;
    localparam int unsigned LEN_SLOT  = 5;
    localparam int unsigned LEN_MOV   = 6;

    // Restoring divide: one quotient bit per step
    localparam logic [2:0] DIV_LAST = 3'd7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_FINISH
    } bsm_state_t;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL
    } alu_op_t;

    typedef struct packed {
        alu_op_t    op;
        logic [8:0] a;
        logic [7:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [8:0] result;
        logic       less;
        logic       equal;
    } alu_rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/bsm_in_if.sv
// Instruction channel: valid/ready handshake carrying one decoded instruction.
// Depends on bsm_pkg for field widths.
`default_nettype none

interface bsm_in_if
    import bsm_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [OP_BITS-1:0]   operation;
    logic [7:0]           immediate;
    logic [SLOT_BITS-1:0] slot_address;
    logic [7:0]           jump_target;

    modport source (
        output valid, operation, immediate, slot_address, jump_target,
        input  ready
    );

    modport sink (
        input  valid, operation, immediate, slot_address, jump_target,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/bsm_out_if.sv
// Status channel: valid/ready handshake carrying the machine state after a step.
// No dependencies.
`default_nettype none

interface bsm_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] next_pc;
    logic [7:0]  top_value;
    logic [7:0]  accumulator_out;
    logic [8:0]  stack_count;
    logic        halted;
    logic [2:0]  fault;

    modport source (
        output valid, next_pc, top_value, accumulator_out, stack_count, halted, fault,
        input  ready
    );

    modport sink (
        input  valid, next_pc, top_value, accumulator_out, stack_count, halted, fault,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/byte_stack_machine_execute.sv
// Execute unit of a byte-wide stack machine with one accumulator: takes one
// decoded instruction per word and returns the machine status after it. Ready
// is high only while the sequencer is idle. For most instructions, the accept
// cycle reads the entry below the top (or the getx slot) through the
// registered read port of the stack RAM, and the next cycle runs the shared
// ALU and writes back. div then runs eight restoring quotient steps, one per
// cycle, through the same ALU. The status word sits in an output register,
// so the next instruction is accepted while it waits; a step that finishes
// before the previous status is taken holds in a finish state. The stack RAM
// needs no clearing pass after reset: the depth works as a fill count, and
// every entry below it has been written since reset.
`default_nettype none
`include "byte_stack_machine_execute_defines.svh"

module byte_stack_machine_execute
    import bsm_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = 256,
    parameter int unsigned PC_BITS     = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bsm_in_if.sink     instr,
    bsm_out_if.source  result
);

    localparam int unsigned AB = $clog2(STACK_DEPTH);
    localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
    localparam logic [DW-1:0] DEPTH_FULL = DW'(STACK_DEPTH);

    bsm_state_t state_reg, state_next;

    logic [PC_BITS-1:0] pc_reg, pc_next, npc;
    logic [7:0]         acc_reg, acc_next;
    logic [7:0]         top_reg, top_next;
    logic [DW-1:0]      depth_reg, depth_next;
    logic               running_reg, running_next;
    bsm_fault_t         fault_reg, fault_next, fault_c;

    // latched instruction
    logic [OP_BITS-1:0]   op_reg;
    logic [7:0]           imm_reg;
    logic [SLOT_BITS-1:0] slot_reg;
    logic [7:0]           target_reg;

    // divide iteration
    logic [7:0] rem_reg, rem_next;
    logic [7:0] quo_reg, quo_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [8:0] trial;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_pc_reg;
    logic [7:0]  out_top_reg;
    logic [7:0]  out_acc_reg;
    logic [8:0]  out_count_reg;
    logic        out_halted_reg;
    logic [2:0]  out_fault_reg;
    logic        out_free, out_load;

    logic          in_accept, in_slot_ok;
    logic          done, div_start, take;
    logic          has1, has2, full, slot_ok, slot_is_top;
    logic [AB-1:0] top_idx, below_idx, push_idx, slot_idx;
    logic [31:0]   pc_wide, depth_wide;

    logic          wr_en;
    logic [AB-1:0] wr_addr, rd_addr;
    logic [7:0]    wr_data, rd_data;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    bsm_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    bsm_stack_ram #(
        .DEPTH     (STACK_DEPTH),
        .ADDR_BITS (AB)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_accept   = (state_reg == S_IDLE) && instr.valid;
    assign instr.ready = (state_reg == S_IDLE);

    assign has1        = (depth_reg != '0);
    assign has2        = (depth_reg >= DW'(2));
    assign full        = (depth_reg == DEPTH_FULL);
    assign top_idx     = AB'(depth_reg - DW'(1));
    assign below_idx   = AB'(depth_reg - DW'(2));
    assign push_idx    = AB'(depth_reg);
    assign slot_idx    = slot_reg[AB-1:0];
    assign slot_ok     = (slot_reg < 32'(depth_reg));
    assign slot_is_top = (slot_reg == (32'(depth_reg) - 32'd1));
    assign in_slot_ok  = (instr.slot_address < 32'(depth_reg));

    assign trial    = {rem_reg, quo_reg[7]};
    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next   = state_reg;
        pc_next      = pc_reg;
        acc_next     = acc_reg;
        top_next     = top_reg;
        depth_next   = depth_reg;
        running_next = running_reg;
        fault_c      = F_NONE;
        npc          = pc_reg + PC_BITS'(LEN_SHORT);
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        div_start    = 1'b0;
        done         = 1'b0;
        take         = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = below_idx;
        wr_data      = alu_rsp.result[7:0];
        alu_req.op   = ALU_SUB;
        alu_req.a    = {1'b0, rd_data};
        alu_req.b    = top_reg;

        // read the entry below the top, or the getx slot, during accept
        if ((instr.operation == OP_GETX) && in_slot_ok)
        begin
            rd_addr = instr.slot_address[AB-1:0];
        end
        else
        begin
            rd_addr = below_idx;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (instr.valid)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (running_reg)
                begin
                    unique case (op_reg)
                        OP_HALT: running_next = 1'b0;
                        OP_PUSH:
                        begin
                            npc = pc_reg + PC_BITS'(LEN_PUSH);
                            if (full)
                            begin
                                fault_c = F_OVER;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = push_idx;
                                wr_data    = imm_reg;
                                depth_next = depth_reg + DW'(1);
                                top_next   = imm_reg;
                            end
                        end
                        OP_POP:
                        begin
                            if (!has1)
                            begin
                                fault_c = F_UNDER;
                            end
                            else
                            begin
                                depth_next = depth_reg - DW'(1);
                                top_next   = has2 ? rd_data : 8'd0;
                            end
                        end
                        OP_ADD, OP_SUB, OP_MUL:
                        begin
                            if (op_reg == OP_ADD)
                            begin
                                alu_req.op = ALU_ADD;
                            end
                            else if (op_reg == OP_MUL)
                            begin
                                alu_req.op = ALU_MUL;
                            end
                            if (!has2)
                            begin
                                fault_c = F_UNDER;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                depth_next = depth_reg - DW'(1);
                                top_next   = alu_rsp.result[7:0];
                            end
                        end
                        OP_DIV:
                        begin
                            if (!has2)
                            begin
                                fault_c = F_UNDER;
                            end
                            else if (top_reg == 8'd0)
                            begin
                                fault_c = F_DIVZ;
                            end
                            else
                            begin
                                // dividend comes from the entry below the top
                                div_start  = 1'b1;
                                rem_next   = 8'd0;
                                quo_next   = rd_data;
                                cnt_next   = 3'd0;
                                state_next = S_DIV;
                            end
                        end
                        OP_MOV, OP_SETX, OP_GETX:
                        begin
                            npc = pc_reg + PC_BITS'((op_reg == OP_MOV) ? LEN_MOV : LEN_SLOT);
                            if (!slot_ok)
                            begin
                                fault_c = F_SLOT;
                            end
                            else if (op_reg == OP_GETX)
                            begin
                                acc_next = rd_data;
                            end
                            else
                            begin
                                wr_en   = 1'b1;
                                wr_addr = slot_idx;
                                wr_data = (op_reg == OP_MOV) ? imm_reg : acc_reg;
                                if (slot_is_top)
                                begin
                                    top_next = wr_data;
                                end
                            end
                        end
                        OP_JMP: npc = PC_BITS'(target_reg);
                        OP_SWAP:
                        begin
                            if (!has1)
                            begin
                                fault_c = F_UNDER;
                            end
                            else
                            begin
                                wr_en    = 1'b1;
                                wr_addr  = top_idx;
                                wr_data  = acc_reg;
                                acc_next = top_reg;
                                top_next = acc_reg;
                            end
                        end
                        OP_PUSHX:
                        begin
                            if (full)
                            begin
                                fault_c = F_OVER;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = push_idx;
                                wr_data    = acc_reg;
                                depth_next = depth_reg + DW'(1);
                                top_next   = acc_reg;
                            end
                        end
                        OP_POPX:
                        begin
                            if (!has1)
                            begin
                                fault_c = F_UNDER;
                            end
                            else
                            begin
                                acc_next   = top_reg;
                                depth_next = depth_reg - DW'(1);
                                top_next   = has2 ? rd_data : 8'd0;
                            end
                        end
                        OP_JE, OP_JNE, OP_JLT, OP_JGT:
                        begin
                            npc       = pc_reg + PC_BITS'(LEN_JUMP);
                            alu_req.a = {1'b0, acc_reg};
                            if (!has1)
                            begin
                                fault_c = F_UNDER;
                            end
                            else
                            begin
                                priority case (op_reg)
                                    OP_JE:   take = alu_rsp.equal;
                                    OP_JNE:  take = !alu_rsp.equal;
                                    OP_JLT:  take = alu_rsp.less;
                                    default: take = !alu_rsp.less && !alu_rsp.equal;
                                endcase
                                if (take)
                                begin
                                    npc = PC_BITS'(target_reg);
                                end
                            end
                        end
                        default: ;
                    endcase
                    if ((fault_c == F_NONE) && !div_start)
                    begin
                        pc_next = npc;
                    end
                end
                done = !div_start;
            end

            S_DIV:
            begin
                alu_req.a = trial;
                quo_next  = {quo_reg[6:0], !alu_rsp.less};
                rem_next  = alu_rsp.less ? trial[7:0] : alu_rsp.result[7:0];
                cnt_next  = cnt_reg + 3'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    done       = 1'b1;
                    wr_en      = 1'b1;
                    wr_addr    = below_idx;
                    wr_data    = quo_next;
                    depth_next = depth_reg - DW'(1);
                    top_next   = quo_next;
                    pc_next    = npc;
                end
            end

            S_FINISH: ;

            default: state_next = S_IDLE;
        endcase

        out_load = (done || (state_reg == S_FINISH)) && out_free;
        if (done || (state_reg == S_FINISH))
        begin
            state_next = out_free ? S_IDLE : S_FINISH;
        end

        fault_next = done ? fault_c : fault_reg;

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign pc_wide    = 32'(pc_next);
    assign depth_wide = 32'(depth_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            acc_reg       <= 8'd0;
            top_reg       <= 8'd0;
            depth_reg     <= '0;
            running_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
            cnt_reg       <= 3'd0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            acc_reg       <= acc_next;
            top_reg       <= top_next;
            depth_reg     <= depth_next;
            running_reg   <= running_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fault_reg <= fault_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        if (in_accept)
        begin
            op_reg     <= instr.operation;
            imm_reg    <= instr.immediate;
            slot_reg   <= instr.slot_address;
            target_reg <= instr.jump_target;
        end
        if (out_load)
        begin
            out_pc_reg     <= pc_wide[15:0];
            out_top_reg    <= top_next;
            out_acc_reg    <= acc_next;
            out_count_reg  <= depth_wide[8:0];
            out_halted_reg <= !running_next;
            out_fault_reg  <= fault_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.next_pc         = out_pc_reg;
    assign result.top_value       = out_top_reg;
    assign result.accumulator_out = out_acc_reg;
    assign result.stack_count     = out_count_reg;
    assign result.halted          = out_halted_reg;
    assign result.fault           = out_fault_reg;

    `BSM_ASSERT_NEXT(a_busy_after_accept, in_accept, !instr.ready)
    `BSM_ASSERT_NEXT(a_halt_sticky, !running_reg, !running_reg)
    `BSM_ASSERT_NEXT(a_fault_no_effect, done && (fault_c != F_NONE), (depth_reg == $past(depth_reg)) && (pc_reg == $past(pc_reg)) && (acc_reg == $past(acc_reg)))
    `BSM_ASSERT_IMPL(a_depth_bound, 1'b1, depth_reg <= DEPTH_FULL)

endmodule

`default_nettype wire

>>> rtl/core/bsm_alu.sv
// Shared byte ALU: add, subtract and multiply, with unsigned compare flags.
// Depends on bsm_pkg for the request and response structs.
`default_nettype none

module bsm_alu
    import bsm_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [9:0]  diff;
    logic [8:0]  sum;
    logic [7:0]  prod;

    assign diff = {1'b0, req.a} - {2'b00, req.b};
    assign sum  = req.a + {1'b0, req.b};
    // keep the low byte of the product only
    assign prod = req.a[7:0] * req.b;

    always_comb
    begin
        unique case (req.op)
            ALU_ADD: rsp.result = sum;
            ALU_SUB: rsp.result = diff[8:0];
            ALU_MUL: rsp.result = {1'b0, prod};
            default: rsp.result = diff[8:0];
        endcase
        // borrow out of the 10-bit difference means a < b
        rsp.less  = diff[9];
        rsp.equal = (diff == 10'd0);
    end

endmodule

`default_nettype wire

>>> rtl/core/bsm_stack_ram.sv
// Stack storage: one write port, one read port with registered read data.
// No dependencies.
`default_nettype none

module bsm_stack_ram #(
    parameter int unsigned DEPTH     = 256,
    parameter int unsigned ADDR_BITS = 8
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [7:0]           wr_data,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output logic      [7:0]           rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire
